// ===== hw/rtl/dwsp_pkg.sv =====
// ----------------------------------------------------------------------------
// dwsp_pkg
// Shared constants, codes and sideband type of the dual-wavelength
// saturation pixel pipeline.
// ----------------------------------------------------------------------------
package dwsp_pkg;

  localparam int PIXEL_BITS_DEF    = 16;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int GAIN_W     = 16;
  localparam int GAIN_FRAC  = 12;
  localparam int BASAL_W    = 24;
  localparam int SAT_W      = 24;
  localparam int THRESH_W   = 21;
  localparam int MASK_W     = THRESH_W + GAIN_FRAC;

  localparam int MANT_FRAC  = 30;
  localparam int MANT_W     = MANT_FRAC + 1;
  localparam int EXP_W      = 7;
  localparam int LOG_BIAS   = GAIN_FRAC;

  localparam int R_LIMIT_INT_BITS = 16;
  localparam int R_SHIFT          = R_LIMIT_INT_BITS + 1;
  localparam int SAT_MAG_BITS     = 24;
  localparam int CONST_W          = 20;

  localparam longint HBO2_L1_X100 = 106200;
  localparam longint HB_L1_X100   = 69108;
  localparam longint HBO2_L2_X100 = 61000;
  localparam longint HB_L2_X100   = 514880;

  localparam longint SAT_MAX_V = 8388607;
  localparam longint SAT_MIN_V = -8388608;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = THRESH_W;

  localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(65535);

  typedef enum logic [1:0] {
    ST_VALID  = 2'd0,
    ST_MASKED = 2'd1,
    ST_DOMAIN = 2'd2
  } pixel_status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MASK_THRESHOLD = CFG_IDX_W'(0),
    REG_MASK_ENABLE    = CFG_IDX_W'(1)
  } cfg_reg_t;

  typedef struct packed {
    logic signed [BASAL_W-1:0] basal;
    pixel_status_t             status;
    logic                      neg;
    logic                      ovf;
  } side_t;

endpackage

// ===== hw/rtl/dual_wavelength_saturation_pixel_top.sv =====
// ----------------------------------------------------------------------------
// dual_wavelength_saturation_pixel_top
// Two-wavelength oxygen saturation per pixel pair: dark and gain
// correction, masking, log ratio and rational formula minus basal level.
//
//   channel  dir  handshake          payload
//   in_      in   tvalid / tready    tdata: pixel pair, darks, gains, basal
//   out_     out  tvalid / tready    tdata: saturation, tuser: pixel status
//   cfg_     in   valid / ready      index, data (always ready)
//
// One word enters per cycle while the output is not stalled; the depth
// comes from the log squaring chain and the two bit-per-stage dividers.
// Reset clears all valid bits and loads the register defaults.
// A stalled output freezes every stage; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module dual_wavelength_saturation_pixel_top
  import dwsp_pkg::*;
#(
  parameter int PIXEL_BITS    = PIXEL_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // top_raw, bottom_raw, top_dark, bottom_dark, top_gain, bottom_gain,
  // basal_level, zero pad
  input  logic [((4*PIXEL_BITS+2*GAIN_W+BASAL_W+7)/8)*8-1:0] in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // saturation
  output logic [SAT_W-1:0]      out_tdata,
  // pixel_status
  output logic [1:0]            out_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PB    = PIXEL_BITS;
  localparam int FB    = FRACTION_BITS;
  localparam int PT_W  = PB + GAIN_W + 1;
  localparam int PW    = PB + GAIN_W;
  localparam int CMP_W = (PT_W > MASK_W) ? PT_W : MASK_W;
  localparam int LW    = FB + EXP_W;
  localparam int W1    = LW + R_SHIFT;
  localparam int S1    = FB + R_SHIFT;
  localparam int RW    = S1 + 1;
  localparam int NW    = RW + CONST_W;
  localparam int IB    = SAT_MAG_BITS - FB;
  localparam int W2    = NW + IB;
  localparam int SW    = SAT_W + 2;
  localparam int O_GT  = 4 * PB;
  localparam int O_GB  = O_GT + GAIN_W;
  localparam int O_BS  = O_GB + GAIN_W;

  localparam logic [S1-1:0]        RLIM  = S1'(1) << (R_LIMIT_INT_BITS + FB);
  localparam logic signed [NW-1:0] K_NA  = NW'(HB_L2_X100);
  localparam logic signed [NW-1:0] K_NB  = NW'(HB_L1_X100) <<< FB;
  localparam logic signed [NW-1:0] K_DA  = NW'(HB_L2_X100 - HBO2_L2_X100);
  localparam logic signed [NW-1:0] K_DB  = NW'(HBO2_L1_X100 - HB_L1_X100) <<< FB;
  localparam logic signed [SW-1:0] R_MAX = SW'(SAT_MAX_V);
  localparam logic signed [SW-1:0] R_MIN = SW'(SAT_MIN_V);

  logic                  en;
  logic [THRESH_W-1:0]   thr_r;
  logic                  men_r;

  logic signed [PB-1:0]  top_raw, bottom_raw, top_dark, bottom_dark;
  logic [GAIN_W-1:0]     top_gain, bottom_gain;
  logic signed [BASAL_W-1:0] basal_level;
  logic signed [PB:0]    dt, db;
  logic signed [PT_W:0]  pt_full, pb_full;

  logic                  s1_v_r;
  logic signed [PT_W-1:0] s1_pt_r, s1_pb_r;
  logic signed [BASAL_W-1:0] s1_basal_r;

  logic [MASK_W-1:0]     lim;
  logic                  hi_t, hi_b;
  side_t                 s2_side_nxt;
  logic                  s2_v_r;
  logic [1:0][PW-1:0]    s2_p_r;
  side_t                 s2_side_r;

  logic                  lg_v;
  logic [1:0][LW-1:0]    lg_l;
  side_t                 lg_side;
  logic signed [LW-1:0]  lt, lb;
  logic [LW-1:0]         abs_lt, abs_lb;
  logic [W1-1:0]         rem1, div1;
  side_t                 p1_side_nxt;
  logic                  p1_v_r;
  logic [W1-1:0]         p1_rem_r, p1_div_r;
  side_t                 p1_side_r;

  logic                  d1_v;
  logic [S1-1:0]         d1_q;
  side_t                 d1_side;
  logic [S1-1:0]         rmag;
  logic                  p2_v_r;
  logic signed [RW-1:0]  p2_r_r;
  side_t                 p2_side_r;

  logic                  p3_v_r;
  logic signed [NW-1:0]  p3_num_r, p3_den_r;
  side_t                 p3_side_r;

  logic [NW-1:0]         abs_num, abs_den;
  logic [W2-1:0]         rem2, div2;
  side_t                 p4_side_nxt;
  logic                  p4_v_r;
  logic [W2-1:0]         p4_rem_r, p4_div_r;
  side_t                 p4_side_r;

  logic                  d2_v;
  logic [SAT_MAG_BITS-1:0] d2_q;
  side_t                 d2_side;
  logic signed [SW-1:0]  sat, res;
  logic [SAT_W-1:0]      res_out;

  logic                  out_valid_r;
  logic [SAT_W-1:0]      out_tdata_r;
  logic [1:0]            out_tuser_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESH_RESET;
      men_r <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MASK_THRESHOLD: thr_r <= cfg_data;
        REG_MASK_ENABLE:    men_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign top_raw     = in_tdata[PB-1:0];
  assign bottom_raw  = in_tdata[2*PB-1:PB];
  assign top_dark    = in_tdata[3*PB-1:2*PB];
  assign bottom_dark = in_tdata[4*PB-1:3*PB];
  assign top_gain    = in_tdata[O_GT+GAIN_W-1:O_GT];
  assign bottom_gain = in_tdata[O_GB+GAIN_W-1:O_GB];
  assign basal_level = in_tdata[O_BS+BASAL_W-1:O_BS];

  always_comb begin
    dt      = (PB+1)'(top_raw) - (PB+1)'(top_dark);
    db      = (PB+1)'(bottom_raw) - (PB+1)'(bottom_dark);
    pt_full = dt * $signed({1'b0, top_gain});
    pb_full = db * $signed({1'b0, bottom_gain});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pt_r    <= pt_full[PT_W-1:0];
      s1_pb_r    <= pb_full[PT_W-1:0];
      s1_basal_r <= basal_level;
    end
  end

  always_comb begin
    lim  = MASK_W'(thr_r) << GAIN_FRAC;
    hi_t = !s1_pt_r[PT_W-1] && (CMP_W'(s1_pt_r[PT_W-2:0]) > CMP_W'(lim));
    hi_b = !s1_pb_r[PT_W-1] && (CMP_W'(s1_pb_r[PT_W-2:0]) > CMP_W'(lim));
    s2_side_nxt.basal = s1_basal_r;
    s2_side_nxt.neg   = 1'b0;
    s2_side_nxt.ovf   = 1'b0;
    priority if (men_r && (hi_t || hi_b)) begin
      s2_side_nxt.status = ST_MASKED;
    end else if (s1_pt_r <= 0 || s1_pb_r <= 0) begin
      s2_side_nxt.status = ST_DOMAIN;
    end else begin
      s2_side_nxt.status = ST_VALID;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_p_r[0] <= s1_pt_r[PW-1:0];
      s2_p_r[1] <= s1_pb_r[PW-1:0];
      s2_side_r <= s2_side_nxt;
    end
  end

  dwsp_log #(
    .PIXEL_BITS    (PIXEL_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_log (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s2_v_r),
    .in_p      (s2_p_r),
    .in_side   (s2_side_r),
    .out_valid (lg_v),
    .out_l     (lg_l),
    .out_side  (lg_side)
  );

  always_comb begin
    lt     = $signed(lg_l[0]);
    lb     = $signed(lg_l[1]);
    abs_lt = lt[LW-1] ? LW'(-lt) : LW'(lt);
    abs_lb = lb[LW-1] ? LW'(-lb) : LW'(lb);
    rem1   = W1'(abs_lt);
    div1   = W1'(abs_lb) << R_SHIFT;
    p1_side_nxt        = lg_side;
    p1_side_nxt.neg    = lt[LW-1] ^ lb[LW-1];
    p1_side_nxt.ovf    = rem1 >= div1;
    if (lg_side.status == ST_VALID && lb == 0) p1_side_nxt.status = ST_DOMAIN;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_rem_r  <= rem1;
      p1_div_r  <= div1;
      p1_side_r <= p1_side_nxt;
    end
  end

  dwsp_div #(
    .W     (W1),
    .STEPS (S1)
  ) u_div_ratio (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (p1_v_r),
    .in_rem    (p1_rem_r),
    .in_div    (p1_div_r),
    .in_side   (p1_side_r),
    .out_valid (d1_v),
    .out_quo   (d1_q),
    .out_side  (d1_side)
  );

  assign rmag = (d1_side.ovf || d1_q > RLIM) ? RLIM : d1_q;

  always_ff @(posedge clk) begin
    if (en) begin
      p2_r_r    <= d1_side.neg ? -RW'(rmag) : RW'(rmag);
      p2_side_r <= d1_side;
      p3_num_r  <= NW'(p2_r_r) * K_NA - K_NB;
      p3_den_r  <= NW'(p2_r_r) * K_DA + K_DB;
      p3_side_r <= p2_side_r;
    end
  end

  always_comb begin
    abs_num = p3_num_r[NW-1] ? NW'(-p3_num_r) : NW'(p3_num_r);
    abs_den = p3_den_r[NW-1] ? NW'(-p3_den_r) : NW'(p3_den_r);
    rem2    = W2'(abs_num);
    div2    = W2'(abs_den) << IB;
    p4_side_nxt     = p3_side_r;
    p4_side_nxt.neg = p3_num_r[NW-1] ^ p3_den_r[NW-1];
    p4_side_nxt.ovf = rem2 >= div2;
    if (p3_side_r.status == ST_VALID && p3_den_r == 0) p4_side_nxt.status = ST_DOMAIN;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p4_rem_r  <= rem2;
      p4_div_r  <= div2;
      p4_side_r <= p4_side_nxt;
    end
  end

  dwsp_div #(
    .W     (W2),
    .STEPS (SAT_MAG_BITS)
  ) u_div_sat (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (p4_v_r),
    .in_rem    (p4_rem_r),
    .in_div    (p4_div_r),
    .in_side   (p4_side_r),
    .out_valid (d2_v),
    .out_quo   (d2_q),
    .out_side  (d2_side)
  );

  always_comb begin
    sat = d2_side.neg ? -SW'(d2_q) : SW'(d2_q);
    res = sat - SW'(d2_side.basal);
    priority if (d2_side.status != ST_VALID) begin
      res_out = '0;
    end else if (d2_side.ovf) begin
      res_out = d2_side.neg ? SAT_W'(R_MIN) : SAT_W'(R_MAX);
    end else if (res > R_MAX) begin
      res_out = SAT_W'(R_MAX);
    end else if (res < R_MIN) begin
      res_out = SAT_W'(R_MIN);
    end else begin
      res_out = res[SAT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= res_out;
      out_tuser_r <= d2_side.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      p3_v_r      <= 1'b0;
      p4_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_v_r      <= in_tvalid;
      s2_v_r      <= s1_v_r;
      p1_v_r      <= lg_v;
      p2_v_r      <= d1_v;
      p3_v_r      <= p2_v_r;
      p4_v_r      <= p3_v_r;
      out_valid_r <= d2_v;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// ===== hw/rtl/dwsp_log.sv =====
// ----------------------------------------------------------------------------
// dwsp_log
// Two-lane fixed-point log2 pipeline: leading-one search, mantissa
// normalization, then one squaring stage per fraction bit.
// ----------------------------------------------------------------------------
module dwsp_log
  import dwsp_pkg::*;
#(
  parameter int PIXEL_BITS    = PIXEL_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic [1:0][PIXEL_BITS+GAIN_W-1:0]      in_p,
  input  side_t                                  in_side,
  output logic                                   out_valid,
  output logic [1:0][FRACTION_BITS+EXP_W-1:0]    out_l,
  output side_t                                  out_side
);

  localparam int PW  = PIXEL_BITS + GAIN_W;
  localparam int EW  = $clog2(PW);
  localparam int NST = FRACTION_BITS;
  localparam int LW  = FRACTION_BITS + EXP_W;

  logic                  a_v_r;
  logic [1:0][PW-1:0]    a_p_r;
  logic [1:0][EW-1:0]    a_e_r;
  logic [1:0][EW-1:0]    a_e_nxt;
  side_t                 a_side_r;

  logic [1:0][MANT_W-1:0] sq_m_r   [0:NST];
  logic [1:0][MANT_W-1:0] sq_m_nxt [0:NST];
  logic [1:0][NST-1:0]    sq_f_r   [0:NST];
  logic [1:0][NST-1:0]    sq_f_nxt [0:NST];
  logic [1:0][EW-1:0]     sq_e_r   [0:NST];
  side_t                  sq_side_r [0:NST];
  logic [NST:0]           sq_v_r;

  logic                  o_v_r;
  logic [1:0][LW-1:0]    o_l_r;
  side_t                 o_side_r;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      a_e_nxt[l] = '0;
      for (int i = 0; i < PW; i++) begin
        if (in_p[l][i]) a_e_nxt[l] = EW'(i);
      end
    end
  end

  always_comb begin
    logic [2*MANT_W-1:0] prod;
    logic [MANT_W:0]     tq;
    prod = '0;
    tq   = '0;
    for (int l = 0; l < 2; l++) begin
      sq_m_nxt[0][l] = MANT_W'({a_p_r[l], {MANT_FRAC{1'b0}}} >> a_e_r[l]);
      sq_f_nxt[0][l] = '0;
    end
    for (int k = 1; k <= NST; k++) begin
      for (int l = 0; l < 2; l++) begin
        prod = sq_m_r[k-1][l] * sq_m_r[k-1][l];
        tq   = prod[2*MANT_FRAC+1:MANT_FRAC];
        sq_m_nxt[k][l] = tq[MANT_W] ? tq[MANT_W:1] : tq[MANT_W-1:0];
        sq_f_nxt[k][l] = {sq_f_r[k-1][l][NST-2:0], tq[MANT_W]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_p_r        <= in_p;
      a_e_r        <= a_e_nxt;
      a_side_r     <= in_side;
      sq_m_r[0]    <= sq_m_nxt[0];
      sq_f_r[0]    <= sq_f_nxt[0];
      sq_e_r[0]    <= a_e_r;
      sq_side_r[0] <= a_side_r;
      for (int k = 1; k <= NST; k++) begin
        sq_m_r[k]    <= sq_m_nxt[k];
        sq_f_r[k]    <= sq_f_nxt[k];
        sq_e_r[k]    <= sq_e_r[k-1];
        sq_side_r[k] <= sq_side_r[k-1];
      end
      for (int l = 0; l < 2; l++) begin
        o_l_r[l] <= {EXP_W'(sq_e_r[NST][l]) - EXP_W'(LOG_BIAS), sq_f_r[NST][l]};
      end
      o_side_r <= sq_side_r[NST];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r  <= 1'b0;
      sq_v_r <= '0;
      o_v_r  <= 1'b0;
    end else if (en) begin
      a_v_r  <= in_valid;
      sq_v_r <= {sq_v_r[NST-1:0], a_v_r};
      o_v_r  <= sq_v_r[NST];
    end
  end

  assign out_valid = o_v_r;
  assign out_l     = o_l_r;
  assign out_side  = o_side_r;

endmodule

// ===== hw/rtl/dwsp_div.sv =====
// ----------------------------------------------------------------------------
// dwsp_div
// Pipelined restoring divider, one quotient bit per stage. The remainder
// must start below the divisor.
// ----------------------------------------------------------------------------
module dwsp_div
  import dwsp_pkg::*;
#(
  parameter int W     = 40,
  parameter int STEPS = 33
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [W-1:0]     in_rem,
  input  logic [W-1:0]     in_div,
  input  side_t            in_side,
  output logic             out_valid,
  output logic [STEPS-1:0] out_quo,
  output side_t            out_side
);

  logic [W-1:0]     rem_r   [0:STEPS-1];
  logic [W-1:0]     rem_nxt [0:STEPS-1];
  logic [W-1:0]     div_r   [0:STEPS-1];
  logic [STEPS-1:0] quo_r   [0:STEPS-1];
  logic [STEPS-1:0] quo_nxt [0:STEPS-1];
  side_t            side_r  [0:STEPS-1];
  logic [STEPS-1:0] v_r;

  always_comb begin
    logic [W-1:0]     src;
    logic [W-1:0]     dv;
    logic [STEPS-1:0] qp;
    logic [W-1:0]     t;
    src = '0;
    dv  = '0;
    qp  = '0;
    t   = '0;
    for (int k = 0; k < STEPS; k++) begin
      src = (k == 0) ? in_rem : rem_r[(k == 0) ? 0 : k-1];
      dv  = (k == 0) ? in_div : div_r[(k == 0) ? 0 : k-1];
      qp  = (k == 0) ? '0     : quo_r[(k == 0) ? 0 : k-1];
      t   = {src[W-2:0], 1'b0};
      if (t >= dv) begin
        rem_nxt[k] = t - dv;
        quo_nxt[k] = {qp[STEPS-2:0], 1'b1};
      end else begin
        rem_nxt[k] = t;
        quo_nxt[k] = {qp[STEPS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r[0]  <= in_div;
      side_r[0] <= in_side;
      for (int k = 1; k < STEPS; k++) begin
        div_r[k]  <= div_r[k-1];
        side_r[k] <= side_r[k-1];
      end
      for (int k = 0; k < STEPS; k++) begin
        rem_r[k] <= rem_nxt[k];
        quo_r[k] <= quo_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[STEPS-2:0], in_valid};
    end
  end

  assign out_valid = v_r[STEPS-1];
  assign out_quo   = quo_r[STEPS-1];
  assign out_side  = side_r[STEPS-1];

endmodule

// ===== hw/rtl/dwsp_checker.sv =====
// ----------------------------------------------------------------------------
// dwsp_checker
// Port-level checks of the saturation pixel pipeline, bound to the top.
// ----------------------------------------------------------------------------
module dwsp_checker
  import dwsp_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [SAT_W-1:0] out_tdata,
  input logic [1:0]       out_tuser
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output word valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output word changed");

  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_VALID |-> out_tdata == '0)
    else $error("flagged word carries nonzero saturation");

  a_accept_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready)
    else $error("input blocked while output can advance");

endmodule

bind dual_wavelength_saturation_pixel_top dwsp_checker u_dwsp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
